FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the sorted list engine.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: property violated");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");

`endif

FILE: rtl/core/sule_pkg.sv
// Types and constants of the sorted list engine.
// No dependencies; imported by the controller, datapath and top level.
package sule_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int COUNT_W  = 6;
   localparam int VALUE_W  = 32;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DELETE = 1'b1;

   typedef struct packed {
      logic                      kind;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]        count;
      logic signed [VALUE_W-1:0] element;
      logic                      has_element;
      logic                      last;
      logic                      dropped_full;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic compare;
      logic update;
      logic emit_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
      logic emit_last;
   } sts_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CMP  = 4'b0010,
      ST_UPD  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

endpackage

FILE: rtl/core/sorted_unique_list_engine_top.sv
// Top level of the sorted list engine; uses sule_pkg, sule_ctrl, sule_dp.
// A request is captured, compared, applied to the store and then read out
// into the result register; no new request is taken until the readout of
// the N results ends (N = list length after the operation, 1 if empty).
// Reset (synchronous, high) empties the list; store contents stay unknown.
module sorted_unique_list_engine_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sule_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sule_pkg::rsp_type  rsp_data
);
   import sule_pkg::*;

   // Flow per request:
   //   idle    - request captured into the datapath
   //   compare - every held entry compared with the value (less / equal flags)
   //   update  - shift of the store for insert or delete
   //   emit    - list read into the result register, one per unstalled cycle
   // The result register lets the next request be accepted while the last
   // result of the previous run is still stalled downstream.
   cmd_type cmd;
   sts_type sts;

   sule_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sule_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/core/sule_ctrl.sv
// Sequencer of the sorted list engine: accept, compare, update, emit.
// Depends on sule_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sule_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sule_pkg::sts_type sts,
   output sule_pkg::cmd_type cmd
);
   import sule_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
            state_in    = ST_UPD;
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_load = 1'b1;
               if (sts.emit_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_stall = (state_ff != ST_IDLE);

   `ASSERT_PROP(a_accept_then_cmp, clock, reset, (req_valid && !req_stall) |=> state_ff == ST_CMP)
   `ASSERT_PROP(a_cmp_then_upd, clock, reset, (state_ff == ST_CMP) |=> state_ff == ST_UPD)
   `ASSERT_PROP(a_onehot_state, clock, reset, $onehot(state_ff))

endmodule

FILE: rtl/core/sule_dp.sv
// Datapath of the sorted list engine: sorted store, compare flags,
// shift update, list readout and the result register.
// Depends on sule_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sule_dp (
   input  logic              clock,
   input  logic              reset,
   input  sule_pkg::req_type  req_data,
   input  sule_pkg::cmd_type  cmd,
   output sule_pkg::sts_type  sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sule_pkg::rsp_type  rsp_data
);
   import sule_pkg::*;

   logic signed [VALUE_W-1:0] store_ff [CAPACITY];
   logic signed [VALUE_W-1:0] store_in [CAPACITY];
   logic [CNT_W-1:0]          held_ff, held_in;
   logic                      kind_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [CAPACITY-1:0]       lt_ff, lt_in, eq_ff, eq_in;
   logic                      dropped_ff, dropped_in;
   logic [IDX_W-1:0]          k_ff, k_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic present, full, do_ins, do_del, empty;

   // per-entry flags; lt is a thermometer since the store is sorted
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         lt_in[i] = (CNT_W'(i) < held_ff) && (store_ff[i] < value_ff);
         eq_in[i] = (CNT_W'(i) < held_ff) && (store_ff[i] == value_ff);
      end
   end

   assign present = |eq_ff;
   assign full    = (held_ff == CNT_W'(CAPACITY));
   assign do_ins  = (kind_ff == KIND_INSERT) && !present && !full;
   assign do_del  = (kind_ff == KIND_DELETE) && present;

   // insert: entries at or above the slot move up; delete: move down
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) store_in[i] = store_ff[i];
      if (do_ins) begin
         if (!lt_ff[0]) store_in[0] = value_ff;
         for (int i = 1; i < CAPACITY; i++) begin
            if (!lt_ff[i]) store_in[i] = lt_ff[i-1] ? value_ff : store_ff[i-1];
         end
      end else if (do_del) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            if (!lt_ff[i]) store_in[i] = store_ff[i+1];
         end
      end
   end

   always_comb begin
      held_in    = held_ff;
      dropped_in = dropped_ff;
      if (cmd.update) begin
         dropped_in = (kind_ff == KIND_INSERT) && !present && full;
         if (do_ins)      held_in = held_ff + CNT_W'(1);
         else if (do_del) held_in = held_ff - CNT_W'(1);
      end
   end

   // readout
   assign empty         = (held_ff == '0);
   assign sts.emit_last = empty || ((CNT_W'(k_ff) + CNT_W'(1)) == held_ff);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      k_in = k_ff;
      if (cmd.update)         k_in = '0;
      else if (cmd.emit_load) k_in = k_ff + IDX_W'(1);
   end

   always_comb begin
      rsp_in              = rsp_ff;
      rsp_in.count        = COUNT_W'(held_ff);
      rsp_in.element      = empty ? '0 : store_ff[k_ff];
      rsp_in.has_element  = !empty;
      rsp_in.last         = sts.emit_last;
      rsp_in.dropped_full = dropped_ff;
      if (cmd.emit_load)   rsp_valid_in = 1'b1;
      else if (rsp_stall)  rsp_valid_in = rsp_valid_ff;
      else                 rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_data.kind;
         value_ff <= req_data.value;
      end
      if (cmd.compare) begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
      if (cmd.update) begin
         for (int i = 0; i < CAPACITY; i++) store_ff[i] <= store_in[i];
      end
      if (cmd.emit_load) rsp_ff <= rsp_in;
      dropped_ff <= dropped_in;
      k_ff       <= k_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_PROP(a_held_bound, clock, reset, held_ff <= CNT_W'(CAPACITY))
   `ASSERT_NEVER(a_load_over_stalled, clock, reset, cmd.emit_load && rsp_valid_ff && rsp_stall)
   `ASSERT_PROP(a_empty_result, clock, reset,
                (rsp_valid_ff && !rsp_ff.has_element) |-> (rsp_ff.last && rsp_ff.count == '0))

endmodule
